// ===== sv/bracket_balance_checker_core_assert.svh =====
// Assertion macros shared by the bracket balance checker RTL.
`ifndef BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bracket checker assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bracket checker assertion failed");
`else
`define BBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/bbc_pkg.sv =====
// Types, constants and the byte decoder for the bracket balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
  localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;

  typedef logic [1:0] code_t;

  localparam code_t CODE_PAREN  = 2'd0;
  localparam code_t CODE_SQUARE = 2'd1;
  localparam code_t CODE_CURLY  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } stack_op_t;

  // Command for the stack row: the op goes to every cell, the push code to cell 0.
  typedef struct packed {
    stack_op_t op;
    code_t     push_code;
  } stack_ctrl_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    code_t code;
  } br_class_t;

  function automatic br_class_t classify(input logic [7:0] b);
    br_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
    unique case (b)
      CH_OPEN_PAREN:   c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_PAREN};
      CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_SQUARE};
      CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_CURLY};
      CH_CLOSE_PAREN:  c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_PAREN};
      CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_SQUARE};
      CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_CURLY};
      default:         c = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
    endcase
    return c;
  endfunction

endpackage

// ===== sv/bbc_cell.sv =====
// One stack cell: holds a bracket code and shifts with its neighbors.
module bbc_cell
  import bbc_pkg::*;
(
  input  logic      clk,
  input  stack_op_t op,
  input  code_t     above,
  input  code_t     below,
  output code_t     code
);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_PUSH: code <= above;
      OP_POP:  code <= below;
      OP_HOLD: code <= code;
      default: code <= code;
    endcase
  end

endmodule

// ===== sv/bbc_stack.sv =====
// Shift-register stack built from a row of cells; cell 0 is the top.
module bbc_stack
  import bbc_pkg::*;
(
  input  logic        clk,
  input  stack_ctrl_t ctrl,
  output code_t       top
);

  code_t cell_code [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    code_t above;
    code_t below;

    if (i == 0) begin : g_first
      assign above = ctrl.push_code;
    end else begin : g_mid_a
      assign above = cell_code[i-1];
    end

    // The bottom cell refills from itself on a pop; that slot is then unused.
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_code[i];
    end else begin : g_mid_b
      assign below = cell_code[i+1];
    end

    bbc_cell u_cell (
      .clk   (clk),
      .op    (ctrl.op),
      .above (above),
      .below (below),
      .code  (cell_code[i])
    );
  end

  assign top = cell_code[0];

endmodule

// ===== sv/bracket_balance_checker_core.sv =====
// Top level of the bracket balance checker: control, counters and result register.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+----------------------
//  input   | in_valid / in_stall | char_byte, is_last
//  output  | out_valid/out_stall | balanced, overflowed
//
// One byte is taken every cycle that in_stall is low; each push or pop shifts the
// whole cell row at once and the match check reads only cell 0, so no stall comes
// from the stack. A result appears on out_valid the cycle after its final byte is
// accepted. Reset clears the depth count, the sticky flags and out_valid; the
// result bits and the cells hold no reset. The input stalls only while a result
// is held and the output side stalls.
module bracket_balance_checker_core
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       balanced,
  output logic       overflowed
);

`include "bracket_balance_checker_core_assert.svh"

  logic [COUNT_W-1:0] stack_count;
  logic [COUNT_W-1:0] stack_count_next;
  logic               mismatch_seen;
  logic               mismatch_seen_next;
  logic               overflow_seen;
  logic               overflow_seen_next;

  br_class_t   cls;
  stack_ctrl_t ctrl;
  code_t       top;
  logic        in_acc;
  logic        active;
  logic        full;
  logic        empty;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign cls      = classify(char_byte);
  assign active   = in_acc && !mismatch_seen;
  assign full     = (stack_count == COUNT_W'(STACK_DEPTH));
  assign empty    = (stack_count == '0);

  always_comb begin
    ctrl.op            = OP_HOLD;
    ctrl.push_code     = cls.code;
    stack_count_next   = stack_count;
    mismatch_seen_next = mismatch_seen;
    overflow_seen_next = overflow_seen;
    if (active && cls.is_open) begin
      if (full) begin
        overflow_seen_next = 1'b1;
      end else begin
        ctrl.op          = OP_PUSH;
        stack_count_next = stack_count + 1'b1;
      end
    end else if (active && cls.is_close) begin
      if (empty) begin
        mismatch_seen_next = 1'b1;
      end else begin
        ctrl.op          = OP_POP;
        stack_count_next = stack_count - 1'b1;
        if (top != cls.code) begin
          mismatch_seen_next = 1'b1;
        end
      end
    end
  end

  bbc_stack u_stack (
    .clk  (clk),
    .ctrl (ctrl),
    .top  (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      mismatch_seen <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_acc && is_last) begin
        // The final byte is applied first, then the string state starts over.
        balanced      <= !mismatch_seen_next && (stack_count_next == '0);
        overflowed    <= overflow_seen_next;
        out_valid     <= 1'b1;
        stack_count   <= '0;
        mismatch_seen <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        if (!out_stall) begin
          out_valid <= 1'b0;
        end
        stack_count   <= stack_count_next;
        mismatch_seen <= mismatch_seen_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  `BBC_ASSERT_IMP(a_count_range, clk, rst, 1'b1, stack_count <= COUNT_W'(STACK_DEPTH))
  `BBC_ASSERT_NEXT(a_clear_after_last, clk, rst, in_acc && is_last, stack_count == '0 && !mismatch_seen && !overflow_seen)
  `BBC_ASSERT_NEXT(a_result_follows, clk, rst, in_acc && is_last, out_valid)
  `BBC_ASSERT_NEXT(a_frozen_after_mismatch, clk, rst, mismatch_seen && !(in_acc && is_last), $stable(stack_count))
  `BBC_ASSERT_IMP(a_stall_needs_result, clk, rst, in_stall, out_valid)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the bracket balance checker core.
`timescale 1ns / 100ps

module testbench;
  import bbc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 6;
  localparam int RANDOM_ITEMS = 200;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         hold;
  } byte_item_t;

  typedef struct packed {
    logic balanced;
    logic overflowed;
  } verdict_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       balanced;
  logic       overflowed;

  byte_item_t pending_bytes[$];
  verdict_t   verdict_q[$];
  byte_item_t cur_item;

  // Shadow copy of the bracket stack and the per-string flags.
  code_t shadow_stack [STACK_DEPTH];
  int    shadow_depth;
  logic  shadow_mismatch;
  logic  shadow_overflow;

  int burst_left;
  int gap_left;
  int stall_phase_left;
  int idle_cycles;
  int fail_count;
  int strings_done;
  int balanced_strings;
  int overflow_strings;
  int bytes_queued;

  bracket_balance_checker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .balanced  (balanced),
    .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] open_char(code_t c);
    case (c)
      CODE_SQUARE: return CH_OPEN_SQUARE;
      CODE_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_PAREN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(code_t c);
    case (c)
      CODE_SQUARE: return CH_CLOSE_SQUARE;
      CODE_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_PAREN;
    endcase
  endfunction

  function automatic code_t random_code();
    return code_t'($urandom_range(0, 2));
  endfunction

  // Advances the shadow stack by one byte and queues a verdict on the final byte.
  function automatic void track_byte(logic [7:0] ch, logic last);
    logic  opening;
    logic  closing;
    code_t c;
    opening = 1'b0;
    closing = 1'b0;
    c = CODE_PAREN;
    case (ch)
      CH_OPEN_PAREN:   begin opening = 1'b1; c = CODE_PAREN; end
      CH_OPEN_SQUARE:  begin opening = 1'b1; c = CODE_SQUARE; end
      CH_OPEN_CURLY:   begin opening = 1'b1; c = CODE_CURLY; end
      CH_CLOSE_PAREN:  begin closing = 1'b1; c = CODE_PAREN; end
      CH_CLOSE_SQUARE: begin closing = 1'b1; c = CODE_SQUARE; end
      CH_CLOSE_CURLY:  begin closing = 1'b1; c = CODE_CURLY; end
      default:         ;
    endcase
    // Once a mismatch is seen the stack stays frozen until the string ends.
    if (!shadow_mismatch) begin
      if (opening) begin
        if (shadow_depth < STACK_DEPTH) begin
          shadow_stack[shadow_depth] = c;
          shadow_depth++;
        end else begin
          shadow_overflow = 1'b1;
        end
      end else if (closing) begin
        if (shadow_depth == 0) begin
          shadow_mismatch = 1'b1;
        end else begin
          shadow_depth--;
          if (shadow_stack[shadow_depth] != c) shadow_mismatch = 1'b1;
        end
      end
    end
    if (last) begin
      verdict_q.push_back('{balanced: !shadow_mismatch && shadow_depth == 0,
                            overflowed: shadow_overflow});
      strings_done++;
      if (!shadow_mismatch && shadow_depth == 0) balanced_strings++;
      if (shadow_overflow) overflow_strings++;
      shadow_depth = 0;
      shadow_mismatch = 1'b0;
      shadow_overflow = 1'b0;
    end
  endfunction

  // Marks the final byte of a string and appends the string to the stimulus.
  task automatic commit_string(byte_item_t s[$], bit hold);
    foreach (s[i]) begin
      s[i].last = (i == s.size() - 1);
      s[i].hold = hold && (i == 0);
      pending_bytes.push_back(s[i]);
    end
    bytes_queued += s.size();
  endtask

  task automatic add_text(string t);
    byte_item_t s[$];
    byte_item_t b;
    for (int i = 0; i < t.len(); i++) begin
      b.ch = t[i];
      s.push_back(b);
    end
    commit_string(s, 1'b0);
  endtask

  task automatic add_single(logic [7:0] ch);
    byte_item_t s[$];
    byte_item_t b;
    b.ch = ch;
    s.push_back(b);
    commit_string(s, 1'b0);
  endtask

  // Long nesting to fill the stack; pushes beyond the depth are dropped.
  task automatic add_deep(int opens, bit bad_first, bit close_all, bit hold);
    byte_item_t s[$];
    byte_item_t b;
    code_t      kept[$];
    code_t      c;
    if (bad_first) begin
      b.ch = close_char(CODE_PAREN);
      s.push_back(b);
    end
    for (int i = 0; i < opens; i++) begin
      c = random_code();
      b.ch = open_char(c);
      s.push_back(b);
      if (kept.size() < STACK_DEPTH) kept.push_back(c);
    end
    if (close_all) begin
      while (kept.size() > 0) begin
        b.ch = close_char(kept.pop_back());
        s.push_back(b);
      end
    end
    commit_string(s, hold);
  endtask

  // Mostly well-formed strings with random noise bytes, some of them broken.
  task automatic add_random_string(bit hold);
    byte_item_t s[$];
    byte_item_t b;
    code_t      open_codes[$];
    code_t      c;
    int         close_pos[$];
    int         len;
    int         flaw;
    int         r;
    int         k;
    len = $urandom_range(1, 24);
    flaw = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        c = random_code();
        open_codes.push_back(c);
        b.ch = open_char(c);
      end else if (r < 65 && open_codes.size() > 0) begin
        close_pos.push_back(s.size());
        b.ch = close_char(open_codes.pop_back());
      end else begin
        b.ch = 8'($urandom_range(0, 255));
      end
      s.push_back(b);
    end
    if (flaw != 1) begin
      while (open_codes.size() > 0) begin
        close_pos.push_back(s.size());
        b.ch = close_char(open_codes.pop_back());
        s.push_back(b);
      end
    end
    if (flaw == 2 && close_pos.size() > 0) begin
      // Swap one closing bracket for a different type.
      k = close_pos[$urandom_range(0, close_pos.size() - 1)];
      case (s[k].ch)
        CH_CLOSE_PAREN:  s[k].ch = ($urandom_range(0, 1) != 0) ? CH_CLOSE_SQUARE : CH_CLOSE_CURLY;
        CH_CLOSE_SQUARE: s[k].ch = ($urandom_range(0, 1) != 0) ? CH_CLOSE_PAREN : CH_CLOSE_CURLY;
        default:         s[k].ch = ($urandom_range(0, 1) != 0) ? CH_CLOSE_PAREN : CH_CLOSE_SQUARE;
      endcase
    end else if (flaw == 3) begin
      b.ch = close_char(random_code());
      s.insert($urandom_range(0, s.size()), b);
    end
    if ($urandom_range(0, 3) == 0) begin
      b.ch = 8'($urandom_range(0, 255));
      s.push_back(b);
    end
    commit_string(s, hold);
  endtask

  // Sender: bursts of back-to-back bytes separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) track_byte(char_byte, is_last);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && verdict_q.size() != 0)) begin
          cur_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          char_byte <= cur_item.ch;
          is_last <= cur_item.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: short stalls, short runs and occasional long free runs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase_left = 0;
    end else if (stall_phase_left > 0) begin
      stall_phase_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_phase_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b1;
      stall_phase_left = $urandom_range(0, 6);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("ERROR: unexpected result balanced=%b overflowed=%b", balanced, overflowed);
      end else begin
        want = verdict_q.pop_front();
        if (balanced !== want.balanced || overflowed !== want.overflowed) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("ERROR: balanced expected %b got %b, overflowed expected %b got %b",
                     want.balanced, balanced, want.overflowed, overflowed);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, verdict_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    fail_count = 0;
    strings_done = 0;
    balanced_strings = 0;
    overflow_strings = 0;
    bytes_queued = 0;
    shadow_depth = 0;
    shadow_mismatch = 1'b0;
    shadow_overflow = 1'b0;

    // Directed: each bracket pair, nesting, lone and crossed brackets, odd bytes.
    add_text("()");
    add_text("[]");
    add_text("{}");
    add_text("([{}])");
    add_text(")");
    add_text("(]");
    add_text("[}");
    add_text("{)");
    add_text("(");
    add_text("}x(");
    add_single(8'h00);
    add_single(8'hFF);

    // Full stack without overflow, overflow then full unwind, overflow left open,
    // and pushes past the depth after a mismatch, which must not flag overflow.
    add_deep(STACK_DEPTH, 1'b0, 1'b1, 1'b1);
    add_deep(STACK_DEPTH + 2, 1'b0, 1'b1, 1'b0);
    add_deep(STACK_DEPTH + 1, 1'b0, 1'b0, 1'b0);
    add_deep(STACK_DEPTH + 1, 1'b1, 1'b0, 1'b0);

    begin
      int target;
      target = bytes_queued + RANDOM_ITEMS;
      add_random_string(1'b1);
      while (bytes_queued < target) add_random_string($urandom_range(0, 40) == 0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d strings from %0d bytes: %0d balanced, %0d with overflow.",
             strings_done, bytes_queued, balanced_strings, overflow_strings);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_cell.sv
sv/bbc_stack.sv
sv/bracket_balance_checker_core.sv
test/testbench.sv
